### hw/rtl/cfa_pkg.sv
package cfa_pkg;

	localparam int POOL_CELLS = 128;
	localparam int ADDR_W     = $clog2(POOL_CELLS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int OWNER_W    = 7;
	localparam int SIZE_W     = 8;
	localparam int FIELD_A_W  = 7;
	localparam int STATUS_W   = 2;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_WORST = 2'd1;
	localparam logic [1:0] MODE_BEST  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOFIT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BEYOND = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic CFG_FIT_MODE  = 1'b0;
	localparam logic CFG_POOL_SIZE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} cfa_state_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [ADDR_W-1:0]  addr;
		logic [OWNER_W-1:0] wdata;
	} mem_req_t;

endpackage

### hw/rtl/contiguous_fit_allocator.sv
// Contiguous fit allocator: a pool of cells, each free or tagged with an owner.
// Command channel: a request word is taken on a rising edge where start is high
// and busy is low. command 0 allocates request_size cells for owner_id using the
// fit_mode policy; command 1 frees request_size cells from start_addr.
// Each request gives exactly one result word: done is high for one cycle with
// status and placed_addr valid. There is no back-pressure on results.
// Configuration channel: cfg_valid/cfg_ready with cfg_index (0 fit_mode,
// 1 pool_size) and cfg_data; cfg_ready is always high. Write only while idle.
// An allocation scans the active pool, reading the owner memory one cell per
// cycle through its single port, then writes the chosen hole in a sweep, one
// cell per cycle; if no hole fits, it answers after the scan. A free runs only
// the write sweep. A zero size or a free beyond the pool is answered straight
// from idle, as is an allocation when the pool size is zero. One request is in
// flight at a time.
// Reset clears fit_mode to first fit, pool_size to 128 and marks every cell
// free at once through per-cell valid bits, so no clearing pass is needed.
module contiguous_fit_allocator
	import cfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic [SIZE_W-1:0]    request_size,
	input  logic [OWNER_W-1:0]   owner_id,
	input  logic [FIELD_A_W-1:0] start_addr,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [FIELD_A_W-1:0] placed_addr,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data
);

	logic [1:0]         fit_mode_q;
	logic [SIZE_W-1:0]  pool_size_q;
	mem_req_t           mem_req;
	logic [OWNER_W-1:0] rd_owner;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q  <= MODE_FIRST;
			pool_size_q <= SIZE_W'(128);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIT_MODE:  fit_mode_q  <= cfg_data[1:0];
				CFG_POOL_SIZE: pool_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cfa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.request_size (request_size),
		.owner_id     (owner_id),
		.start_addr   (start_addr),
		.fit_mode     (fit_mode_q),
		.pool_size    (pool_size_q),
		.mem_req      (mem_req),
		.rd_owner     (rd_owner),
		.done         (done),
		.status       (status),
		.placed_addr  (placed_addr)
	);

	cfa_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rd_owner (rd_owner)
	);

endmodule

### hw/rtl/cfa_mem.sv
module cfa_mem
	import cfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mem_req_t           req,
	output logic [OWNER_W-1:0] rd_owner
);

	logic [OWNER_W-1:0] mem [POOL_CELLS];
	logic [POOL_CELLS-1:0] valid_q;
	logic [OWNER_W-1:0] rd_data_s1;
	logic               rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_s1 <= mem[req.addr];
		end
	end

	// A cell that was never written since reset reads as free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_s1 <= valid_q[req.addr];
			end
		end
	end

	assign rd_owner = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

### hw/rtl/cfa_ctrl.sv
module cfa_ctrl
	import cfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic [SIZE_W-1:0]    request_size,
	input  logic [OWNER_W-1:0]   owner_id,
	input  logic [FIELD_A_W-1:0] start_addr,
	input  logic [1:0]           fit_mode,
	input  logic [SIZE_W-1:0]    pool_size,
	output mem_req_t             mem_req,
	input  logic [OWNER_W-1:0]   rd_owner,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [FIELD_A_W-1:0] placed_addr
);

	cfa_state_t state_q, state_d;

	logic                 cmd_q, cmd_d;
	logic [SIZE_W-1:0]    size_q, size_d;
	logic [OWNER_W-1:0]   wval_q, wval_d;
	logic [1:0]           mode_q, mode_d;
	logic [CNT_W-1:0]     n_q, n_d;
	logic [CNT_W-1:0]     iss_q, iss_d;
	logic                 proc_vld_s1, proc_vld_d;
	logic [ADDR_W-1:0]    proc_idx_s1, proc_idx_d;
	logic [ADDR_W-1:0]    run_start_q, run_start_d;
	logic [CNT_W-1:0]     run_len_q, run_len_d;
	logic                 found_q, found_d;
	logic [ADDR_W-1:0]    pick_q, pick_d;
	logic [CNT_W-1:0]     pick_len_q, pick_len_d;
	logic [ADDR_W-1:0]    wptr_q, wptr_d;
	logic [SIZE_W-1:0]    wleft_q, wleft_d;
	logic                 done_q, done_d;
	logic [STATUS_W-1:0]  status_q, status_d;
	logic [FIELD_A_W-1:0] placed_q, placed_d;

	logic [CNT_W-1:0]  n_act;
	logic              accept;
	logic              cand_ok;
	logic [ADDR_W-1:0] cand_start;
	logic [CNT_W-1:0]  cand_len;
	logic              cand_take;
	logic              last_cell;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		if (32'(pool_size) > POOL_CELLS) begin
			n_act = CNT_W'(POOL_CELLS);
		end else begin
			n_act = CNT_W'(pool_size);
		end
	end

	// Judges the hole that closes at the cell under processing, if one does.
	always_comb begin
		cand_ok    = 1'b0;
		cand_start = run_start_q;
		cand_len   = run_len_q;
		last_cell  = ({1'b0, proc_idx_s1} == n_q - CNT_W'(1));
		if (proc_vld_s1) begin
			if (rd_owner == '0) begin
				cand_ok  = last_cell;
				cand_len = run_len_q + CNT_W'(1);
				if (run_len_q == '0) begin
					cand_start = proc_idx_s1;
				end
			end else begin
				cand_ok = (run_len_q != '0);
			end
		end
		cand_take = cand_ok && (32'(cand_len) >= 32'(size_q)) &&
			(!found_q ||
			 ((mode_q == MODE_WORST) && (cand_len > pick_len_q)) ||
			 ((mode_q == MODE_BEST) && (cand_len < pick_len_q)));
	end

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		size_d      = size_q;
		wval_d      = wval_q;
		mode_d      = mode_q;
		n_d         = n_q;
		iss_d       = iss_q;
		proc_vld_d  = 1'b0;
		proc_idx_d  = proc_idx_s1;
		run_start_d = run_start_q;
		run_len_d   = run_len_q;
		found_d     = found_q;
		pick_d      = pick_q;
		pick_len_d  = pick_len_q;
		wptr_d      = wptr_q;
		wleft_d     = wleft_q;
		done_d      = 1'b0;
		status_d    = status_q;
		placed_d    = placed_q;
		mem_req     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_d       = command;
					size_d      = request_size;
					mode_d      = fit_mode;
					n_d         = n_act;
					iss_d       = '0;
					run_start_d = '0;
					run_len_d   = '0;
					found_d     = 1'b0;
					pick_d      = '0;
					pick_len_d  = '0;
					placed_d    = '0;
					if (command == CMD_ALLOC) begin
						wval_d = owner_id;
						if ((request_size == '0) || (n_act == '0)) begin
							done_d   = 1'b1;
							status_d = STAT_NOFIT;
						end else begin
							state_d = ST_SCAN;
						end
					end else begin
						wval_d = '0;
						if (request_size == '0) begin
							done_d   = 1'b1;
							status_d = STAT_DONE;
						end else if ((32'(start_addr) + 32'(request_size)) > 32'(n_act)) begin
							done_d   = 1'b1;
							status_d = STAT_BEYOND;
						end else begin
							wptr_d  = ADDR_W'(start_addr);
							wleft_d = request_size;
							state_d = ST_WRITE;
						end
					end
				end
			end
			ST_SCAN: begin
				if (iss_q < n_q) begin
					mem_req.re   = 1'b1;
					mem_req.addr = iss_q[ADDR_W-1:0];
					iss_d        = iss_q + CNT_W'(1);
					proc_vld_d   = 1'b1;
					proc_idx_d   = iss_q[ADDR_W-1:0];
				end
				if (proc_vld_s1) begin
					if (rd_owner == '0) begin
						if (run_len_q == '0) begin
							run_start_d = proc_idx_s1;
						end
						run_len_d = run_len_q + CNT_W'(1);
					end else begin
						run_len_d = '0;
					end
					if (cand_take) begin
						found_d    = 1'b1;
						pick_d     = cand_start;
						pick_len_d = cand_len;
					end
					if (last_cell) begin
						if (found_d) begin
							wptr_d  = pick_d;
							wleft_d = size_q;
							state_d = ST_WRITE;
						end else begin
							done_d   = 1'b1;
							status_d = STAT_NOFIT;
							state_d  = ST_IDLE;
						end
					end
				end
			end
			ST_WRITE: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = wptr_q;
				mem_req.wdata = wval_q;
				wptr_d        = wptr_q + ADDR_W'(1);
				wleft_d       = wleft_q - SIZE_W'(1);
				if (wleft_q == SIZE_W'(1)) begin
					done_d   = 1'b1;
					status_d = STAT_DONE;
					placed_d = (cmd_q == CMD_ALLOC) ? FIELD_A_W'(pick_q) : '0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			proc_vld_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			proc_vld_s1 <= proc_vld_d;
			done_q      <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		size_q      <= size_d;
		wval_q      <= wval_d;
		mode_q      <= mode_d;
		n_q         <= n_d;
		iss_q       <= iss_d;
		proc_idx_s1 <= proc_idx_d;
		run_start_q <= run_start_d;
		run_len_q   <= run_len_d;
		found_q     <= found_d;
		pick_q      <= pick_d;
		pick_len_q  <= pick_len_d;
		wptr_q      <= wptr_d;
		wleft_q     <= wleft_d;
		status_q    <= status_d;
		placed_q    <= placed_d;
	end

	assign done        = done_q;
	assign status      = status_q;
	assign placed_addr = placed_q;

	a_refused_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q != STAT_DONE)) |-> (placed_q == '0))
		else $error("refused request reports a start cell");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((status_q == STAT_DONE) || (status_q == STAT_NOFIT) ||
			(status_q == STAT_BEYOND)))
		else $error("result word carries an unknown status");

	a_scan_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> ((iss_q < n_q) && (state_q == ST_SCAN)))
		else $error("scan reads outside the active pool");

	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (wleft_q != '0))
		else $error("write sweep with no cells left");

	a_pick_fits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && found_q) |-> (32'(pick_len_q) >= 32'(size_q)))
		else $error("chosen hole is shorter than the request");

endmodule
